### rtl/ptc_pkg.sv
// shared types and constants for the pressure/temperature compensation pipeline
`default_nettype none
package ptc_pkg;

  // field widths
  localparam int RAW_W     = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 32;

  // first-order temperature base, 20.00 degrees
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  // calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENS   = 3'd0,
    REG_PRESSURE_OFFSET = 3'd1,
    REG_SENS_TEMP_COEFF = 3'd2,
    REG_OFF_TEMP_COEFF  = 3'd3,
    REG_REF_TEMP        = 3'd4,
    REG_TEMP_COEFF      = 3'd5
  } ptc_reg_t;

  // calibration words
  typedef struct packed {
    logic [CFG_W-1:0] pressure_sensitivity;
    logic [CFG_W-1:0] pressure_offset;
    logic [CFG_W-1:0] sensitivity_temp_coeff;
    logic [CFG_W-1:0] offset_temp_coeff;
    logic [CFG_W-1:0] reference_temperature;
    logic [CFG_W-1:0] temperature_coeff;
  } ptc_cfg_t;

  // first-order results leaving the front end
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;   // first-order temperature
    logic signed [17:0]       tdev;   // temp - 2000
    logic                     low;    // below 20 degrees
    logic [16:0]              ti;     // second-order temperature term
    logic signed [35:0]       off;
    logic signed [34:0]       sens;
  } ptc_front_t;

  // corrected terms leaving the second-order stages
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [37:0]       off_c;
    logic signed [36:0]       sens_c;
  } ptc_second_t;

  // stage handshake between pipeline sections
  typedef struct packed {
    logic valid;
    logic en;
  } ptc_hs_t;

endpackage
`default_nettype wire

### rtl/ptc_cfg_regs.sv
// calibration register file with its write port
`default_nettype none
module ptc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptc_pkg::CFG_W-1:0]     cfg_data,
  output ptc_pkg::ptc_cfg_t                  cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register decode, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptc_pkg::REG_PRESSURE_SENS:   cfg.pressure_sensitivity   <= cfg_data;
        ptc_pkg::REG_PRESSURE_OFFSET: cfg.pressure_offset        <= cfg_data;
        ptc_pkg::REG_SENS_TEMP_COEFF: cfg.sensitivity_temp_coeff <= cfg_data;
        ptc_pkg::REG_OFF_TEMP_COEFF:  cfg.offset_temp_coeff      <= cfg_data;
        ptc_pkg::REG_REF_TEMP:        cfg.reference_temperature  <= cfg_data;
        ptc_pkg::REG_TEMP_COEFF:      cfg.temperature_coeff      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/ptc_front.sv
// stages one to three: dT, the dT products and the first-order terms
`default_nettype none
module ptc_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [ptc_pkg::RAW_W-1:0] raw_pressure,
  input  wire logic [ptc_pkg::RAW_W-1:0] raw_temperature,
  input  wire ptc_pkg::ptc_cfg_t         cfg,
  input  wire logic                      dn_en,
  output ptc_pkg::ptc_hs_t               up,
  output logic                           out_valid,
  output ptc_pkg::ptc_front_t            out
);

  logic                      s1_valid, s2_valid;
  logic                      en1, en2, en3;
  logic [ptc_pkg::RAW_W-1:0] s1_d1, s2_d1;
  logic signed [24:0]        s1_dt;
  logic signed [24:0]        dt_next;
  logic signed [41:0]        s2_pt, s2_poff, s2_psens;
  logic [47:0]               s2_dtsq;
  logic signed [49:0]        dtsq_full;
  logic signed [17:0]        tdev_next;
  logic [51:0]               ti_full;
  ptc_pkg::ptc_front_t       out_next;

  // a stage moves when it is empty or the next one moves
  assign en3 = !out_valid || dn_en;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign up.valid = s1_valid;
  assign up.en    = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) out_valid <= s2_valid;
    end
  end

  // stage one: temperature difference against the reference
  assign dt_next = $signed({1'b0, raw_temperature})
                 - $signed({1'b0, cfg.reference_temperature, 8'h00});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d1 <= raw_pressure;
      s1_dt <= dt_next;
    end
  end

  // stage two: the four products of dT
  assign dtsq_full = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d1    <= s1_d1;
      s2_pt    <= s1_dt * $signed({1'b0, cfg.temperature_coeff});
      s2_poff  <= s1_dt * $signed({1'b0, cfg.offset_temp_coeff});
      s2_psens <= s1_dt * $signed({1'b0, cfg.sensitivity_temp_coeff});
      s2_dtsq  <= dtsq_full[47:0];
    end
  end

  // stage three: shifts, first-order offset and sensitivity, 11 * dT^2 >> 35
  assign tdev_next = $signed(s2_pt[40:23]);
  assign ti_full   = {1'b0, s2_dtsq, 3'b000} + {3'b000, s2_dtsq, 1'b0}
                   + {4'h0, s2_dtsq};

  always_comb begin
    out_next.d1   = s2_d1;
    out_next.tdev = tdev_next;
    out_next.low  = tdev_next[17];
    out_next.temp = ptc_pkg::TEMP_BASE + ptc_pkg::TEMP_W'(tdev_next);
    out_next.ti   = ti_full[51:35];
    out_next.off  = $signed({3'b000, cfg.pressure_offset, 17'h00000})
                  + $signed(s2_poff[41:6]);
    out_next.sens = $signed({3'b000, cfg.pressure_sensitivity, 16'h0000})
                  + $signed(s2_psens[41:7]);
  end

  always_ff @(posedge clk) begin
    if (en3) out <= out_next;
  end

endmodule
`default_nettype wire

### rtl/ptc_second.sv
// stages four and five: second-order corrections below 20 degrees
`default_nettype none
module ptc_second (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire ptc_pkg::ptc_front_t in_data,
  input  wire logic                dn_en,
  output ptc_pkg::ptc_hs_t         up,
  output logic                     out_valid,
  output ptc_pkg::ptc_second_t     out
);

  logic                 s4_valid;
  logic                 en4, en5;
  ptc_pkg::ptc_front_t  s4_f;
  logic [34:0]          s4_dev;
  logic signed [35:0]   dev_full;
  logic [39:0]          offi_x31;
  logic [40:0]          sensi_x63;
  logic signed [37:0]   offi;
  logic signed [36:0]   sensi;
  logic signed [ptc_pkg::TEMP_W-1:0] ti;
  ptc_pkg::ptc_second_t out_next;

  assign en5 = !out_valid || dn_en;
  assign en4 = !s4_valid || en5;
  assign up.valid = s4_valid;
  assign up.en    = en4;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en4) s4_valid  <= in_valid;
      if (en5) out_valid <= s4_valid;
    end
  end

  // stage four: square of the temperature deviation
  assign dev_full = in_data.tdev * in_data.tdev;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_f   <= in_data;
      s4_dev <= dev_full[34:0];
    end
  end

  // stage five: 31*dev>>3 and 63*dev>>5, applied only when cold
  assign offi_x31  = {s4_dev, 5'h00} - {5'h00, s4_dev};
  assign sensi_x63 = {s4_dev, 6'h00} - {6'h00, s4_dev};

  always_comb begin
    offi  = '0;
    sensi = '0;
    ti    = '0;
    if (s4_f.low) begin
      offi  = $signed({1'b0, offi_x31[39:3]});
      sensi = $signed({1'b0, sensi_x63[40:5]});
      ti    = $signed({2'b00, s4_f.ti});
    end
    out_next.d1     = s4_f.d1;
    out_next.temp   = s4_f.temp - ti;
    out_next.off_c  = 38'(s4_f.off) - offi;
    out_next.sens_c = 37'(s4_f.sens) - sensi;
  end

  always_ff @(posedge clk) begin
    if (en5) out <= out_next;
  end

endmodule
`default_nettype wire

### rtl/ptc_press.sv
// stages six to eight: raw pressure times sensitivity, offset removal, output register
`default_nettype none
module ptc_press (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire ptc_pkg::ptc_second_t          in_data,
  input  wire logic                          out_stall,
  output ptc_pkg::ptc_hs_t                   up,
  output logic                               out_valid,
  output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi,
  output logic signed [ptc_pkg::PRES_W-1:0]  pressure_centi
);

  logic                              s6_valid, s7_valid;
  logic                              en6, en7, en8;
  logic [43:0]                       s6_pp_lo;
  logic signed [41:0]                s6_pp_hi;
  logic signed [37:0]                s6_off, s7_off;
  logic signed [ptc_pkg::TEMP_W-1:0] s6_temp, s7_temp;
  logic [61:0]                       prod_full;
  logic signed [40:0]                s7_sh;
  logic signed [41:0]                diff;

  assign en8 = !out_valid || !out_stall;
  assign en7 = !s7_valid || en8;
  assign en6 = !s6_valid || en7;
  assign up.valid = s6_valid;
  assign up.en    = en6;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en6) s6_valid  <= in_valid;
      if (en7) s7_valid  <= s6_valid;
      if (en8) out_valid <= s7_valid;
    end
  end

  // stage six: d1 times the low 20 and the signed high 17 bits of the sensitivity
  always_ff @(posedge clk) begin
    if (en6) begin
      s6_pp_lo <= in_data.d1 * in_data.sens_c[19:0];
      s6_pp_hi <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens_c[36:20]);
      s6_off   <= in_data.off_c;
      s6_temp  <= in_data.temp;
    end
  end

  // stage seven: join the partial products, then >> 21
  assign prod_full = {s6_pp_hi, 20'h00000} + {18'h00000, s6_pp_lo};

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_sh   <= $signed(prod_full[61:21]);
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
    end
  end

  // stage eight: subtract the offset, then >> 15
  // the result stays within 27 bits, so the signed 32-bit clamp never engages
  assign diff = 42'(s7_sh) - 42'(s7_off);

  always_ff @(posedge clk) begin
    if (en8) begin
      temperature_centi <= s7_temp;
      pressure_centi    <= ptc_pkg::PRES_W'($signed(diff[41:15]));
    end
  end

endmodule
`default_nettype wire

### rtl/pressure_temperature_compensation.sv
// top level of the second-order barometric compensation pipeline
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | sink      | in_valid / in_stall  | raw_pressure, raw_temperature
//   out     | source    | out_valid / out_stall| temperature_centi, pressure_centi
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// eight register stages, one beat in and one beat out per cycle while out_stall stays low
// stage enables ripple back from out_stall, so empty stages keep filling while the
// output beat waits; in_stall rises only once every stage holds a beat
// rst is synchronous: clears valid bits and the calibration words to zero
// cfg_ready is always high; writes to indexes past five are dropped
`default_nettype none
module pressure_temperature_compensation (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [ptc_pkg::RAW_W-1:0]            raw_pressure,
  input  wire logic [ptc_pkg::RAW_W-1:0]            raw_temperature,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [ptc_pkg::TEMP_W-1:0]         temperature_centi,
  output logic signed [ptc_pkg::PRES_W-1:0]         pressure_centi,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ptc_pkg::CFG_W-1:0]            cfg_data
);

  ptc_pkg::ptc_cfg_t    cfg;
  ptc_pkg::ptc_hs_t     front_hs, second_hs, press_hs;
  logic                 front_valid, second_valid;
  ptc_pkg::ptc_front_t  front_data;
  ptc_pkg::ptc_second_t second_data;

  // calibration words
  ptc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // first-order terms
  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .cfg             (cfg),
    .dn_en           (second_hs.en),
    .up              (front_hs),
    .out_valid       (front_valid),
    .out             (front_data)
  );

  // second-order corrections
  ptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .dn_en     (press_hs.en),
    .up        (second_hs),
    .out_valid (second_valid),
    .out       (second_data)
  );

  // pressure and output register
  ptc_press u_press (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (second_valid),
    .in_data           (second_data),
    .out_stall         (out_stall),
    .up                (press_hs),
    .out_valid         (out_valid),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

  assign in_stall = !front_hs.en;

  // input back-pressure only when the whole pipe is full and the output is held
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && front_hs.valid && second_hs.valid
                  && press_hs.valid))
    else $error("in_stall raised with room in the pipeline");

  // a beat accepted with a free output path reaches out_valid
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the output in eight cycles");

  // pipeline comes out of reset empty and open
  a_reset_empty : assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### test/compensation_checker.sv
// checker for the compensation pipeline: follows calibration writes, predicts and compares results
`timescale 1ns / 1ps
module compensation_checker (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       in_valid,
  input  wire logic                                       in_stall,
  input  wire logic [ptc_pkg::RAW_W-1:0]                  raw_pressure,
  input  wire logic [ptc_pkg::RAW_W-1:0]                  raw_temperature,
  input  wire logic                                       out_valid,
  input  wire logic                                       out_stall,
  input  wire logic signed [ptc_pkg::TEMP_W-1:0]          temperature_centi,
  input  wire logic signed [ptc_pkg::PRES_W-1:0]          pressure_centi,
  input  wire logic                                       cfg_valid,
  input  wire logic                                       cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  wire logic [ptc_pkg::CFG_W-1:0]                  cfg_data,
  output int                                              mismatches,
  output int                                              pending_results,
  output int                                              results_checked,
  output int                                              cold_results
);

  localparam int     REPORT_LIMIT = 10;
  localparam longint PRES_MAX     = 64'sd2147483647;
  localparam longint PRES_MIN     = -64'sd2147483648;

  typedef struct {
    logic signed [ptc_pkg::TEMP_W-1:0] temperature;
    logic signed [ptc_pkg::PRES_W-1:0] pressure;
    bit                                cold;
  } reading_t;

  ptc_pkg::ptc_cfg_t calibration;
  reading_t          expected_readings[$];

  // compensated temperature and pressure for one pair of raw samples
  function automatic reading_t compensate(input ptc_pkg::ptc_cfg_t c,
                                          input logic [ptc_pkg::RAW_W-1:0] d1_raw,
                                          input logic [ptc_pkg::RAW_W-1:0] d2_raw);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, temp, off, sens, ti, offi, sensi, dev, p;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = c.pressure_sensitivity;
    c2 = c.pressure_offset;
    c3 = c.sensitivity_temp_coeff;
    c4 = c.offset_temp_coeff;
    c5 = c.reference_temperature;
    c6 = c.temperature_coeff;

    // first order
    dt   = d2 - c5 * 256;
    temp = ptc_pkg::TEMP_BASE + ((dt * c6) >>> 23);
    off  = c2 * 131072 + ((c4 * dt) >>> 6);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);

    // second-order terms only below 20 degrees
    ti     = 0;
    offi   = 0;
    sensi  = 0;
    r.cold = temp < ptc_pkg::TEMP_BASE;
    if (r.cold) begin
      dev   = (temp - ptc_pkg::TEMP_BASE) * (temp - ptc_pkg::TEMP_BASE);
      ti    = (11 * dt * dt) >>> 35;
      offi  = (31 * dev) >>> 3;
      sensi = (63 * dev) >>> 5;
    end

    temp -= ti;
    p = (((d1 * (sens - sensi)) >>> 21) - (off - offi)) >>> 15;
    if (p > PRES_MAX)
      p = PRES_MAX;
    else if (p < PRES_MIN)
      p = PRES_MIN;

    r.temperature = temp[ptc_pkg::TEMP_W-1:0];
    r.pressure    = p[ptc_pkg::PRES_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : track
    reading_t want;
    if (rst) begin
      calibration = '0;
      expected_readings.delete();
    end else begin
      // calibration beat, spare indexes dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptc_pkg::REG_PRESSURE_SENS:   calibration.pressure_sensitivity   = cfg_data;
          ptc_pkg::REG_PRESSURE_OFFSET: calibration.pressure_offset        = cfg_data;
          ptc_pkg::REG_SENS_TEMP_COEFF: calibration.sensitivity_temp_coeff = cfg_data;
          ptc_pkg::REG_OFF_TEMP_COEFF:  calibration.offset_temp_coeff      = cfg_data;
          ptc_pkg::REG_REF_TEMP:        calibration.reference_temperature  = cfg_data;
          ptc_pkg::REG_TEMP_COEFF:      calibration.temperature_coeff      = cfg_data;
          default: ;
        endcase
      end

      // input beat
      if (in_valid && !in_stall)
        expected_readings.push_back(compensate(calibration, raw_pressure, raw_temperature));

      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat with none predicted: temp %0d pres %0d",
                     $time, temperature_centi, pressure_centi);
        end else begin
          want = expected_readings.pop_front();
          results_checked++;
          if (want.cold)
            cold_results++;
          if (temperature_centi !== want.temperature || pressure_centi !== want.pressure) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: result %0d: expected temp %0d pres %0d, got temp %0d pres %0d",
                       $time, results_checked, want.temperature, want.pressure,
                       temperature_centi, pressure_centi);
          end
        end
      end
    end
    pending_results = expected_readings.size();
  end

endmodule

### test/tb.sv
// testbench top for the compensation pipeline: clock, reset, stimulus, calibration and verdict
`timescale 1ns / 1ps
module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 190;
  localparam int RAND_PHASES = 6;
  localparam int HOLD_CYCLES = 48;
  localparam int MAX_WAIT    = 11;

  // indexes past the last calibration word
  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [ptc_pkg::RAW_W-1:0] RAW_MAX  = '1;
  localparam logic [ptc_pkg::CFG_W-1:0] WORD_MAX = '1;

  logic                              clk             = 1'b0;
  logic                              rst             = 1'b1;
  logic                              in_valid        = 1'b0;
  logic                              in_stall;
  logic [ptc_pkg::RAW_W-1:0]         raw_pressure    = '0;
  logic [ptc_pkg::RAW_W-1:0]         raw_temperature = '0;
  logic                              out_valid;
  logic                              out_stall       = 1'b0;
  logic signed [ptc_pkg::TEMP_W-1:0] temperature_centi;
  logic signed [ptc_pkg::PRES_W-1:0] pressure_centi;
  logic                              cfg_valid       = 1'b0;
  logic                              cfg_ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index       = '0;
  logic [ptc_pkg::CFG_W-1:0]         cfg_data        = '0;

  int                mismatches, pending_results, results_checked, cold_results;
  int                readings_sent = 0;
  int                cal_sets      = 0;
  int                quiet_cycles  = 0;
  int                receiver_hold = 0;
  bit                sender_fast   = 1'b0;
  bit                receiver_fast = 1'b0;
  ptc_pkg::ptc_cfg_t cal           = '0;

  pressure_temperature_compensation dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  compensation_checker result_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending_results   (pending_results),
    .results_checked   (results_checked),
    .cold_results      (cold_results)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: stall drawn per beat, with a long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      if (receiver_hold > 0) begin
        n = receiver_hold;
        receiver_hold = 0;
      end else if (receiver_fast) begin
        n = 0;
      end else begin
        n = $urandom_range(0, MAX_WAIT);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one sample pair, after a drawn gap; valid stays high for a back-to-back beat
  task automatic send_reading(input logic [ptc_pkg::RAW_W-1:0] d1,
                              input logic [ptc_pkg::RAW_W-1:0] d2);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (in_stall);
    readings_sent++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [ptc_pkg::CFG_IDX_W-1:0] idx,
                          input logic [ptc_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all six words, with writes to the spare indexes mixed in
  task automatic load_calibration(input ptc_pkg::ptc_cfg_t c);
    cfg_beat(ptc_pkg::REG_PRESSURE_SENS, c.pressure_sensitivity);
    cfg_beat(ptc_pkg::REG_PRESSURE_OFFSET, c.pressure_offset);
    cfg_beat(REG_SPARE_LO, ptc_pkg::CFG_W'($urandom));
    cfg_beat(ptc_pkg::REG_SENS_TEMP_COEFF, c.sensitivity_temp_coeff);
    cfg_beat(ptc_pkg::REG_OFF_TEMP_COEFF, c.offset_temp_coeff);
    cfg_beat(ptc_pkg::REG_REF_TEMP, c.reference_temperature);
    cfg_beat(REG_SPARE_HI, ptc_pkg::CFG_W'($urandom));
    cfg_beat(ptc_pkg::REG_TEMP_COEFF, c.temperature_coeff);
    cfg_valid <= 1'b0;
    cal = c;
    cal_sets++;
  endtask

  // calibration word biased towards the extremes
  function automatic logic [ptc_pkg::CFG_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return WORD_MAX;
      default: return ptc_pkg::CFG_W'($urandom);
    endcase
  endfunction

  function automatic ptc_pkg::ptc_cfg_t random_calibration();
    ptc_pkg::ptc_cfg_t c;
    c.pressure_sensitivity   = random_word();
    c.pressure_offset        = random_word();
    c.sensitivity_temp_coeff = random_word();
    c.offset_temp_coeff      = random_word();
    c.reference_temperature  = random_word();
    c.temperature_coeff      = random_word();
    return c;
  endfunction

  function automatic logic [ptc_pkg::RAW_W-1:0] random_pressure_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return ptc_pkg::RAW_W'($urandom);
    endcase
  endfunction

  // half full range, half spread around the reference so both sides of 20 degrees are hit
  function automatic logic [ptc_pkg::RAW_W-1:0] random_temperature_raw();
    longint centre, v, r;
    int     span;
    if ($urandom_range(0, 1) == 0)
      return ptc_pkg::RAW_W'($urandom);
    span   = $urandom_range(0, 23);
    centre = cal.reference_temperature;
    centre = centre * 256;
    r      = $urandom_range(0, 1 << (span + 1));
    v      = centre + r - (longint'(1) << span);
    if (v < 0)
      v = 0;
    else if (v > RAW_MAX)
      v = RAW_MAX;
    return v[ptc_pkg::RAW_W-1:0];
  endfunction

  initial begin : stimulus
    ptc_pkg::ptc_cfg_t         c;
    logic [ptc_pkg::RAW_W-1:0] centre;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-scale calibration: raw extremes, zero dT and one count below it
    drain();
    c = '1;
    load_calibration(c);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    centre = {c.reference_temperature, 8'h00};
    send_reading(RAW_MAX, centre);
    send_reading(RAW_MAX, centre - 1'b1);

    // typical sensor calibration: exactly 20 degrees, just below, normal, extremes
    drain();
    c = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    load_calibration(c);
    centre = {c.reference_temperature, 8'h00};
    send_reading(24'd4958179, centre);
    send_reading(24'd4958179, centre - 1'b1);
    send_reading(24'd4958179, 24'd6815414);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);

    // all words zero
    drain();
    load_calibration('0);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'h5A5A5A, 24'hA5A5A5);

    // mixed extremes
    drain();
    c = '{16'd0, WORD_MAX, WORD_MAX, 16'd0, 16'd0, WORD_MAX};
    load_calibration(c);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, '0);

    // random phases, each with a stretch of no idling; first phase backs the pipe up
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      load_calibration(random_calibration());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        receiver_fast = (i >= 60 && i < 90);
        sender_fast   = receiver_fast || (ph == 0 && i >= 120 && i < 150);
        if (ph == 0 && i == 120)
          receiver_hold = HOLD_CYCLES;
        send_reading(random_pressure_raw(), random_temperature_raw());
      end
    end
    sender_fast   = 1'b0;
    receiver_fast = 1'b0;

    // flush and settle
    drain();
    repeat (16) @(posedge clk);

    $display("%0d sample pairs over %0d calibration sets, %0d results checked",
             readings_sent, cal_sets, results_checked);
    $display("%0d results took the below-20-degree correction", cold_results);
    if (mismatches == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### pressure_temperature_compensation.f
rtl/ptc_pkg.sv
rtl/ptc_cfg_regs.sv
rtl/ptc_front.sv
rtl/ptc_second.sv
rtl/ptc_press.sv
rtl/pressure_temperature_compensation.sv
test/compensation_checker.sv
test/tb.sv
